FILE: design/bss_pkg.sv
// ----------------------------------------------------------------------------
// bss_pkg: shared types and constants of the byte shuffle scrambler
// Status, phase, operation and register codes, and the queue entry that
// passes from the front part to the back part.
// ----------------------------------------------------------------------------
package bss_pkg;

  localparam int BLOCK_SIZE_DEFAULT = 127;
  localparam int BLOCK_SIZE_MAX     = 255;
  localparam int ADDR_W_MAX         = 8;
  localparam int QUEUE_DEPTH        = 4;
  localparam int CFG_INDEX_W        = 8;
  localparam int CFG_DATA_W         = 8;
  localparam int MIN_LENGTH_W       = 7;

  localparam logic [7:0] HEAD_KEY_RESET   = 8'h3c;
  localparam logic [7:0] TAIL_KEY_RESET   = 8'hc3;
  localparam logic [6:0] MIN_LENGTH_RESET = 7'd7;

  localparam logic [CFG_INDEX_W-1:0] REG_DIRECTION  = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_HEAD_KEY   = 8'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_TAIL_KEY   = 8'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_MIN_LENGTH = 8'd3;

  localparam logic [1:0] ST_DELIVERED = 2'd0;
  localparam logic [1:0] ST_STORED    = 2'd1;
  localparam logic [1:0] ST_REFUSED   = 2'd2;
  localparam logic [1:0] ST_EMPTY     = 2'd3;

  localparam logic [1:0] PH_FILL_FIRST  = 2'd0;
  localparam logic [1:0] PH_FILL_LATER  = 2'd1;
  localparam logic [1:0] PH_DRAIN_FIRST = 2'd2;
  localparam logic [1:0] PH_DRAIN_LATER = 2'd3;

  localparam logic [1:0] OP_REPLY = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  typedef struct packed {
    logic [1:0]            op;
    logic [ADDR_W_MAX-1:0] addr;
    logic [7:0]            data;
    logic [1:0]            status;
    logic                  head_xor;
    logic                  tail_xor;
    logic                  eom;
  } bss_entry_t;

endpackage

FILE: design/bss_front.sv
// ----------------------------------------------------------------------------
// bss_front: item classification and block bookkeeping
// Holds fill count, read pointer, phase and end flag, decides the result
// status of each item and works out the store address of a push or a pull.
// ----------------------------------------------------------------------------
module bss_front #(
  parameter int BLOCK_SIZE = bss_pkg::BLOCK_SIZE_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               accept,
  input  logic               mode,
  input  logic [7:0]         data_byte,
  input  logic               last_byte,
  input  logic               direction,
  input  logic [7:0]         head_key,
  input  logic [7:0]         tail_key,
  input  logic [6:0]         min_length,
  output bss_pkg::bss_entry_t entry
);

  localparam int CW    = $clog2(BLOCK_SIZE + 1);
  localparam int AW    = $clog2(BLOCK_SIZE);
  localparam int SW    = CW + 1;
  localparam int CMP_W = (CW > bss_pkg::MIN_LENGTH_W) ? CW : bss_pkg::MIN_LENGTH_W;

  logic [CW-1:0] fill_count, fill_count_next;
  logic [CW-1:0] read_pointer, read_pointer_next;
  logic [1:0]    phase, phase_next;
  logic          ended_in_block, ended_in_block_next;

  logic [SW-1:0] n, p, half, src, pos_half;
  logic [CW-1:0] fill_inc;
  logic          shuffled, at_last;
  logic [7:0]    wbyte;

  always_comb begin
    entry               = '0;
    fill_count_next     = fill_count;
    read_pointer_next   = read_pointer;
    phase_next          = phase;
    ended_in_block_next = ended_in_block;
    fill_inc            = fill_count + CW'(1);
    wbyte               = data_byte;
    n                   = SW'(fill_count);
    p                   = SW'(read_pointer);
    if (p >= n) begin
      p = n - SW'(1);
    end
    half     = (n + SW'(1)) >> 1;
    pos_half = p - half;
    shuffled = (phase == bss_pkg::PH_DRAIN_FIRST) &&
               (CMP_W'(fill_count) >= CMP_W'(min_length));
    src      = p;
    if (shuffled) begin
      if (!direction) begin
        src = p[0] ? (half + (p >> 1)) : (p >> 1);
      end else begin
        src = (p < half) ? (p << 1) : ((pos_half << 1) + SW'(1));
      end
    end
    if (src >= n) begin
      src = n - SW'(1);
    end
    at_last = ended_in_block && (p == n - SW'(1));

    if (!mode) begin
      if (phase[1] || (fill_count >= CW'(BLOCK_SIZE))) begin
        entry.op     = bss_pkg::OP_REPLY;
        entry.status = bss_pkg::ST_REFUSED;
      end else begin
        if (!direction && (phase == bss_pkg::PH_FILL_FIRST) && (fill_count == '0)) begin
          wbyte = wbyte ^ head_key;
        end
        if (!direction && last_byte) begin
          wbyte = wbyte ^ tail_key;
        end
        entry.op     = bss_pkg::OP_WRITE;
        entry.addr   = bss_pkg::ADDR_W_MAX'(fill_count[AW-1:0]);
        entry.data   = wbyte;
        entry.status = bss_pkg::ST_STORED;
        fill_count_next = fill_inc;
        if (last_byte) begin
          ended_in_block_next = 1'b1;
          phase_next          = {1'b1, phase[0]};
        end else if (fill_inc >= CW'(BLOCK_SIZE)) begin
          ended_in_block_next = 1'b0;
          phase_next          = {1'b1, phase[0]};
        end
      end
    end else begin
      if (!phase[1] || (fill_count == '0)) begin
        entry.op     = bss_pkg::OP_REPLY;
        entry.status = bss_pkg::ST_EMPTY;
      end else begin
        entry.op       = bss_pkg::OP_READ;
        entry.addr     = bss_pkg::ADDR_W_MAX'(src[AW-1:0]);
        entry.status   = bss_pkg::ST_DELIVERED;
        entry.head_xor = direction && (phase == bss_pkg::PH_DRAIN_FIRST) && (p == '0);
        entry.tail_xor = direction && at_last;
        entry.eom      = at_last;
        if (p + SW'(1) >= n) begin
          read_pointer_next   = '0;
          fill_count_next     = '0;
          phase_next          = ended_in_block ? bss_pkg::PH_FILL_FIRST
                                               : bss_pkg::PH_FILL_LATER;
          ended_in_block_next = 1'b0;
        end else begin
          read_pointer_next = p[CW-1:0] + CW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count     <= '0;
      read_pointer   <= '0;
      phase          <= bss_pkg::PH_FILL_FIRST;
      ended_in_block <= 1'b0;
    end else if (accept) begin
      fill_count     <= fill_count_next;
      read_pointer   <= read_pointer_next;
      phase          <= phase_next;
      ended_in_block <= ended_in_block_next;
    end
  end

endmodule

FILE: design/bss_queue.sv
// ----------------------------------------------------------------------------
// bss_queue: short queue between the front and back parts
// A small first-in first-out buffer of classified items.
// ----------------------------------------------------------------------------
module bss_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  bss_pkg::bss_entry_t push_entry,
  input  logic                pop,
  output bss_pkg::bss_entry_t head,
  output logic                valid,
  output logic                full
);

  localparam int QW = $clog2(bss_pkg::QUEUE_DEPTH);

  bss_pkg::bss_entry_t slots [bss_pkg::QUEUE_DEPTH];
  logic [QW-1:0] wr_ptr, rd_ptr;
  logic [QW:0]   count;

  assign valid = (count != '0);
  assign full  = (count == (QW + 1)'(bss_pkg::QUEUE_DEPTH));
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QW'(bss_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr + QW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QW'(bss_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr + QW'(1);
      end
      if (push && !pop) begin
        count <= count + (QW + 1)'(1);
      end else if (pop && !push) begin
        count <= count - (QW + 1)'(1);
      end
    end
  end

endmodule

FILE: design/bss_back.sv
// ----------------------------------------------------------------------------
// bss_back: block store access and result output
// Carries out the store writes and reads in queue order, applies the
// reverse keys and holds each result in an output register.
// ----------------------------------------------------------------------------
module bss_back #(
  parameter int BLOCK_SIZE = bss_pkg::BLOCK_SIZE_DEFAULT
) (
  input  logic                clk,
  input  logic                rst,
  input  bss_pkg::bss_entry_t q_head,
  input  logic                q_valid,
  output logic                q_pop,
  input  logic [7:0]          head_key,
  input  logic [7:0]          tail_key,
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [7:0]          m_tdata,
  output logic [1:0]          m_tuser,
  output logic                m_tlast
);

  localparam int AW = $clog2(BLOCK_SIZE);

  logic [7:0]          block_store [BLOCK_SIZE];
  logic [7:0]          rdata;
  bss_pkg::bss_entry_t stage;
  logic                stage_valid;
  logic                stage_adv;
  logic [7:0]          result_byte;

  assign stage_adv = stage_valid && (!m_tvalid || m_tready);
  assign q_pop     = q_valid && (!stage_valid || stage_adv);

  always_ff @(posedge clk) begin
    if (q_pop && (q_head.op == bss_pkg::OP_WRITE)) begin
      block_store[q_head.addr[AW-1:0]] <= q_head.data;
    end
    if (q_pop && (q_head.op == bss_pkg::OP_READ)) begin
      rdata <= block_store[q_head.addr[AW-1:0]];
    end
    if (q_pop) begin
      stage <= q_head;
    end
  end

  always_comb begin
    result_byte = '0;
    if (stage.op == bss_pkg::OP_READ) begin
      result_byte = rdata ^ (stage.head_xor ? head_key : 8'h00)
                          ^ (stage.tail_xor ? tail_key : 8'h00);
    end
  end

  always_ff @(posedge clk) begin
    if (stage_adv) begin
      m_tdata <= result_byte;
      m_tuser <= stage.status;
      m_tlast <= stage.eom;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
      m_tvalid    <= 1'b0;
    end else begin
      if (q_pop) begin
        stage_valid <= 1'b1;
      end else if (stage_adv) begin
        stage_valid <= 1'b0;
      end
      if (stage_adv) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

endmodule

FILE: design/byte_shuffle_scrambler.sv
// ----------------------------------------------------------------------------
// byte_shuffle_scrambler: message scrambler and unscrambler
// The block takes one item per clock cycle while its four-entry queue has
// room, and returns exactly one result item per input item, in order. A
// result passes through the queue, block store read and output register and
// waits there while the receiver holds off. Push items store message bytes
// into a block of up to BLOCK_SIZE bytes; pull items read a message's first
// block of min_length bytes or more in perfect-shuffle order (or its inverse
// when the direction register is set), other blocks in stored order, with
// the head and tail keys applied to the first and last message bytes. The
// single-port block store sets the rate: one access per item.
// ----------------------------------------------------------------------------
module byte_shuffle_scrambler #(
  parameter int BLOCK_SIZE = bss_pkg::BLOCK_SIZE_DEFAULT
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [7:0]                       s_tdata,   // data_byte
  input  logic                             s_tuser,   // mode
  input  logic                             s_tlast,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [7:0]                       m_tdata,   // out_byte
  output logic [1:0]                       m_tuser,   // status
  output logic                             m_tlast,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [bss_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [bss_pkg::CFG_DATA_W-1:0]   cfg_data
);

  logic                direction;
  logic [7:0]          head_key;
  logic [7:0]          tail_key;
  logic [6:0]          min_length;
  logic                accept;
  logic                q_valid, q_full, q_pop;
  bss_pkg::bss_entry_t front_entry, q_head;

  assign cfg_ready = 1'b1;
  assign s_tready  = !q_full;
  assign accept    = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      direction  <= 1'b0;
      head_key   <= bss_pkg::HEAD_KEY_RESET;
      tail_key   <= bss_pkg::TAIL_KEY_RESET;
      min_length <= bss_pkg::MIN_LENGTH_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        bss_pkg::REG_DIRECTION:  direction  <= cfg_data[0];
        bss_pkg::REG_HEAD_KEY:   head_key   <= cfg_data;
        bss_pkg::REG_TAIL_KEY:   tail_key   <= cfg_data;
        bss_pkg::REG_MIN_LENGTH: min_length <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  bss_front #(.BLOCK_SIZE(BLOCK_SIZE)) u_front (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .mode       (s_tuser),
    .data_byte  (s_tdata),
    .last_byte  (s_tlast),
    .direction  (direction),
    .head_key   (head_key),
    .tail_key   (tail_key),
    .min_length (min_length),
    .entry      (front_entry)
  );

  bss_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (accept),
    .push_entry (front_entry),
    .pop        (q_pop),
    .head       (q_head),
    .valid      (q_valid),
    .full       (q_full)
  );

  bss_back #(.BLOCK_SIZE(BLOCK_SIZE)) u_back (
    .clk      (clk),
    .rst      (rst),
    .q_head   (q_head),
    .q_valid  (q_valid),
    .q_pop    (q_pop),
    .head_key (head_key),
    .tail_key (tail_key),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  a_result_payload: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (m_tuser != bss_pkg::ST_DELIVERED)) |-> ((m_tdata == 8'h00) && !m_tlast))
    else $error("non-delivery result carries a byte or an end mark");

  a_pop_needs_entry: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_valid)
    else $error("queue popped while empty");

  a_accept_queued: assert property (@(posedge clk) disable iff (rst)
    accept |=> q_valid)
    else $error("accepted item missing from queue");

endmodule

FILE: bench/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: testbench for the byte shuffle scrambler
// Sends push and pull items and register writes, keeps a behavioural copy of
// the block store, its fill and read state and the shuffle order, and checks
// every result item in order against that copy. A directed part covers the
// special cases; random phases with changing register settings, random gaps
// on both sides and one long receiver hold-off cover the rest.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int BLOCK         = 127;
  localparam bit MODE_PUSH     = 1'b0;
  localparam bit MODE_PULL     = 1'b1;
  localparam int SETTLE_CYCLES = 8;
  localparam int LONG_HOLD     = 200;
  localparam int CYCLE_LIMIT   = 800000;

  typedef struct packed {
    logic [7:0] out_byte;
    logic [1:0] status;
    logic       eom;
  } shuffle_result_t;

  logic                            clk       = 1'b0;
  logic                            rst       = 1'b1;
  logic                            s_tvalid  = 1'b0;
  logic                            s_tready;
  logic [7:0]                      s_tdata   = '0;   // data_byte
  logic                            s_tuser   = 1'b0; // mode
  logic                            s_tlast   = 1'b0;
  logic                            m_tvalid;
  logic                            m_tready  = 1'b0;
  logic [7:0]                      m_tdata;          // out_byte
  logic [1:0]                      m_tuser;          // status
  logic                            m_tlast;
  logic                            cfg_valid = 1'b0;
  logic                            cfg_ready;
  logic [bss_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
  logic [bss_pkg::CFG_DATA_W-1:0]  cfg_data  = '0;

  // Mirror of the registers and of the block state.
  logic       dir_reg      = 1'b0;
  logic [7:0] head_key_reg = bss_pkg::HEAD_KEY_RESET;
  logic [7:0] tail_key_reg = bss_pkg::TAIL_KEY_RESET;
  logic [6:0] min_len_reg  = bss_pkg::MIN_LENGTH_RESET;
  logic [7:0] blk_mem [BLOCK];
  int         fill_cnt     = 0;
  int         rd_ptr       = 0;
  logic [1:0] blk_phase    = bss_pkg::PH_FILL_FIRST;
  logic       holds_end    = 1'b0;

  shuffle_result_t shuffle_results_due[$];
  int errors         = 0;
  bit tx_gaps        = 1'b1;
  bit rx_gaps        = 1'b1;
  int hold_request   = 0;
  int msg_bytes_left = 0;

  byte_shuffle_scrambler #(.BLOCK_SIZE(BLOCK)) uut (.*);

  initial begin
    forever #6 clk = ~clk;
  end

  function automatic int pick_gap(input bit enabled);
    int r;
    r = $urandom_range(0, 99);
    if (!enabled || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic int pick_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return $urandom_range(1, 8);
    if (r < 85) return $urandom_range(9, 30);
    if (r < 97) return $urandom_range(31, 100);
    return $urandom_range(120, 200);
  endfunction

  function automatic logic [6:0] pick_min_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return 7'($urandom_range(1, 12));
    if (r < 85) return 7'd127;
    return 7'($urandom_range(1, 127));
  endfunction

  // Works out the result of one item and advances the mirrored state.
  function automatic shuffle_result_t predict_shuffle_item(input bit mode,
                                                           input logic [7:0] data,
                                                           input bit last);
    shuffle_result_t r;
    logic [7:0]      b;
    int              n, p, half, src;
    r = '{out_byte: 8'h00, status: bss_pkg::ST_STORED, eom: 1'b0};
    b = data;
    if (mode == MODE_PUSH) begin
      if (blk_phase >= bss_pkg::PH_DRAIN_FIRST || fill_cnt >= BLOCK) begin
        r.status = bss_pkg::ST_REFUSED;
      end else begin
        if (dir_reg == 1'b0) begin
          if (blk_phase == bss_pkg::PH_FILL_FIRST && fill_cnt == 0) b ^= head_key_reg;
          if (last) b ^= tail_key_reg;
        end
        blk_mem[fill_cnt] = b;
        fill_cnt++;
        if (last || fill_cnt >= BLOCK) begin
          holds_end = last;
          blk_phase = (blk_phase == bss_pkg::PH_FILL_FIRST) ? bss_pkg::PH_DRAIN_FIRST
                                                            : bss_pkg::PH_DRAIN_LATER;
        end
      end
    end else if (blk_phase < bss_pkg::PH_DRAIN_FIRST || fill_cnt == 0) begin
      r.status = bss_pkg::ST_EMPTY;
    end else begin
      n    = fill_cnt;
      p    = (rd_ptr >= n) ? n - 1 : rd_ptr;
      half = (n + 1) >> 1;
      src  = p;
      if (blk_phase == bss_pkg::PH_DRAIN_FIRST && fill_cnt >= min_len_reg) begin
        if (dir_reg == 1'b0) src = p[0] ? half + (p >> 1) : p >> 1;
        else src = (p < half) ? 2 * p : 2 * (p - half) + 1;
      end
      if (src >= n) src = n - 1;
      r.out_byte = blk_mem[src];
      if (dir_reg == 1'b1) begin
        if (blk_phase == bss_pkg::PH_DRAIN_FIRST && p == 0) r.out_byte ^= head_key_reg;
        if (holds_end && p == n - 1) r.out_byte ^= tail_key_reg;
      end
      r.eom    = holds_end && p == n - 1;
      r.status = bss_pkg::ST_DELIVERED;
      rd_ptr   = p + 1;
      if (rd_ptr >= n) begin
        rd_ptr    = 0;
        fill_cnt  = 0;
        blk_phase = holds_end ? bss_pkg::PH_FILL_FIRST : bss_pkg::PH_FILL_LATER;
        holds_end = 1'b0;
      end
    end
    return r;
  endfunction

  task automatic send_item(input bit mode, input logic [7:0] data, input bit last);
    int gap;
    s_tvalid <= 1'b1;
    s_tuser  <= mode;
    s_tdata  <= data;
    s_tlast  <= last;
    do @(posedge clk); while (s_tready !== 1'b1);
    shuffle_results_due.push_back(predict_shuffle_item(mode, data, last));
    gap = pick_gap(tx_gaps);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (shuffle_results_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Leaves cfg_valid high so that writes can follow back to back.
  task automatic write_reg(input logic [bss_pkg::CFG_INDEX_W-1:0] idx,
                           input logic [7:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    case (idx)
      bss_pkg::REG_DIRECTION:  dir_reg      = val[0];
      bss_pkg::REG_HEAD_KEY:   head_key_reg = val;
      bss_pkg::REG_TAIL_KEY:   tail_key_reg = val;
      bss_pkg::REG_MIN_LENGTH: min_len_reg  = val[6:0];
      default: ;
    endcase
  endtask

  task automatic apply_settings(input logic dir, input logic [7:0] head,
                                input logic [7:0] tail, input logic [6:0] min_len);
    wait_idle();
    write_reg(bss_pkg::REG_DIRECTION, {7'd0, dir});
    write_reg(bss_pkg::REG_HEAD_KEY, head);
    write_reg(bss_pkg::REG_TAIL_KEY, tail);
    write_reg(bss_pkg::REG_MIN_LENGTH, {1'b0, min_len});
    cfg_valid <= 1'b0;
  endtask

  // Pushes a whole message and pulls out every block as soon as it is due.
  task automatic run_message(input int len);
    for (int i = 0; i < len; i++) begin
      send_item(MODE_PUSH, 8'($urandom), i == len - 1);
      while (blk_phase >= bss_pkg::PH_DRAIN_FIRST) begin
        send_item(MODE_PULL, 8'($urandom), 1'($urandom));
      end
    end
  endtask

  task automatic random_item();
    logic [7:0] data;
    bit         last;
    data = 8'($urandom);
    if (blk_phase >= bss_pkg::PH_DRAIN_FIRST) begin
      if ($urandom_range(0, 99) < 8) send_item(MODE_PUSH, data, 1'($urandom));
      else send_item(MODE_PULL, data, 1'($urandom));
    end else if ($urandom_range(0, 99) < 5) begin
      send_item(MODE_PULL, data, 1'($urandom));
    end else begin
      if (msg_bytes_left == 0) msg_bytes_left = pick_length();
      last = (msg_bytes_left == 1) || ($urandom_range(0, 99) < 2);
      send_item(MODE_PUSH, data, last);
      msg_bytes_left = last ? 0 : msg_bytes_left - 1;
    end
  endtask

  // Reset settings: empty pull, one-byte message, refused push, short and
  // minimum-length messages.
  task automatic test_basic_messages();
    send_item(MODE_PULL, 8'h00, 1'b0);
    send_item(MODE_PUSH, 8'hff, 1'b1);
    send_item(MODE_PUSH, 8'h00, 1'b0);
    send_item(MODE_PULL, 8'hff, 1'b1);
    send_item(MODE_PULL, 8'h55, 1'b0);
    run_message(3);
    run_message(7);
  endtask

  // A full first block without an end mark, followed by a pass-through block.
  task automatic test_full_block();
    apply_settings(1'b0, 8'ha5, 8'h5a, 7'd127);
    run_message(131);
  endtask

  // The receiver holds off while the sender keeps offering items.
  task automatic test_backpressure();
    apply_settings(1'b1, 8'($urandom), 8'($urandom), 7'd5);
    tx_gaps      = 1'b0;
    hold_request = LONG_HOLD;
    repeat (40) random_item();
    tx_gaps = 1'b1;
  endtask

  // Random phases; settings change while a message may be half written.
  task automatic test_random_settings();
    for (int k = 0; k < 12; k++) begin
      case (k)
        0: apply_settings(1'b0, 8'h00, 8'hff, 7'd1);
        1: apply_settings(1'b1, 8'hff, 8'h00, 7'd127);
        2: apply_settings(1'b1, 8'($urandom), 8'($urandom), 7'd1);
        default: apply_settings(1'($urandom), 8'($urandom), 8'($urandom), pick_min_length());
      endcase
      tx_gaps = (k % 4) != 3;
      rx_gaps = (k % 3) != 2;
      repeat (110) random_item();
    end
  endtask

  initial begin : result_monitor
    int              gap;
    shuffle_result_t due;
    gap = 0;
    forever begin
      @(posedge clk);
      if (m_tvalid && m_tready) begin
        if (shuffle_results_due.size() == 0) begin
          $error("Unexpected result item: out_byte %0h status %0d end_of_message %0b",
                 m_tdata, m_tuser, m_tlast);
          errors++;
        end else begin
          due = shuffle_results_due.pop_front();
          if (m_tdata !== due.out_byte) begin
            $error("out_byte: expected %0h, got %0h", due.out_byte, m_tdata);
            errors++;
          end
          if (m_tuser !== due.status) begin
            $error("status: expected %0d, got %0d", due.status, m_tuser);
            errors++;
          end
          if (m_tlast !== due.eom) begin
            $error("end_of_message: expected %0b, got %0b", due.eom, m_tlast);
            errors++;
          end
        end
      end
      if (hold_request > 0) begin
        gap          = hold_request;
        hold_request = 0;
      end else if (gap == 0 && $urandom_range(0, 3) == 0) begin
        gap = pick_gap(rx_gaps);
      end
      if (gap > 0) begin
        m_tready <= 1'b0;
        gap--;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  initial begin : watchdog
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin : test_sequence
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    test_basic_messages();
    test_full_block();
    test_backpressure();
    test_random_settings();
    wait_idle();
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
